// ===== rtl/kef_pkg.sv =====
`default_nettype none

package kef_pkg;

   // default queue depth
   localparam int unsigned KEF_DEPTH = 16;

   localparam int unsigned KEY_W    = 32;
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   // command opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_EXTRACT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXTRACT
   } kef_state_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic shift;   // take the key of the right-hand neighbor
      logic wr_en;   // load wr_data into the cell at wr_pos
   } kef_cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/kef_cell.sv =====
`default_nettype none

module kef_cell
   import kef_pkg::*;
#(
   parameter int unsigned IDX   = 0,
   parameter int unsigned IDX_W = 4
) (
   input  wire logic                  clock,
   input  wire kef_cell_ctl_type      ctl,
   input  wire logic [IDX_W-1:0]      wr_pos,
   input  wire logic [KEY_W-1:0]      wr_data,
   input  wire logic [KEY_W-1:0]      next_key,
   output logic      [KEY_W-1:0]      key
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             sel;

   assign sel = ctl.wr_en && (wr_pos == IDX_W'(IDX));

   // load at our slot, else advance from the neighbor, else hold
   always_comb begin
      if (sel) begin
         key_in = wr_data;
      end else if (ctl.shift) begin
         key_in = next_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

`default_nettype wire

// ===== rtl/keyed_extract_fifo_core.sv =====
`default_nettype none

// Ordered key queue with push, pop and keyed extract.
// Request channel: req_opcode and req_key, taken when req_valid is high and
// req_stall is low. Result channel: one beat per request with rsp_status,
// rsp_key_out, rsp_ahead_count, rsp_behind_count and rsp_occupancy, taken
// when rsp_valid is high and rsp_stall is low.
// The keys sit in a row of DEPTH cells with the head in cell 0; every cell
// shifts its key toward the head when the row advances.
// Push, pop and the unused opcode finish in the accept cycle: the result is
// valid in the cycle after the request beat. Extract on a queue holding n keys
// rotates the row once per cycle through the single head comparator, each
// kept key rejoining at the tail, and its result is loaded once all n keys
// have been examined (an empty queue answers as a push or pop does). A new
// request is taken in the cycle after the result register is loaded if rsp_stall is low.
// While the receiver stalls, the result beat holds in its output register
// and req_stall stays high until that beat is taken.
// Reset empties the queue and drops any pending result; the key cells are
// not cleared, since only cells below the fill count are ever read.

module keyed_extract_fifo_core
   import kef_pkg::*;
#(
   parameter int unsigned DEPTH = KEF_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [KEY_W-1:0]     req_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [KEY_W-1:0]     rsp_key_out,
   output logic      [COUNT_W-1:0]   rsp_ahead_count,
   output logic      [COUNT_W-1:0]   rsp_behind_count,
   output logic      [COUNT_W-1:0]   rsp_occupancy
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   kef_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     left_ff, left_in;     // keys not yet examined
   logic [CNT_W-1:0]     kept_ff, kept_in;     // keys already rejoined
   logic                 found_ff, found_in;
   logic [COUNT_W-1:0]   ahead_ff, ahead_in;
   logic [COUNT_W-1:0]   behind_ff, behind_in;
   logic [KEY_W-1:0]     xkey_ff, xkey_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0]   rsp_ahead_ff, rsp_ahead_in;
   logic [COUNT_W-1:0]   rsp_behind_ff, rsp_behind_in;
   logic [COUNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   kef_cell_ctl_type     ctl;
   logic [IDX_W-1:0]     wr_pos;
   logic [KEY_W-1:0]     wr_data;
   logic [KEY_W-1:0]     cell_key [DEPTH];
   logic [KEY_W-1:0]     head;
   logic [CNT_W-1:0]     tail_pos;
   logic                 match;
   logic                 rsp_free;
   logic                 req_accept;

   // row of key cells, head in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] nbr;
      if (i == DEPTH - 1) begin : g_last
         assign nbr = cell_key[i];
      end else begin : g_mid
         assign nbr = cell_key[i+1];
      end
      kef_cell #(
         .IDX   (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .wr_pos   (wr_pos),
         .wr_data  (wr_data),
         .next_key (nbr),
         .key      (cell_key[i])
      );
   end

   assign head       = cell_key[0];
   assign match      = (head == xkey_ff);
   assign tail_pos   = left_ff + kept_ff - CNT_W'(1);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // sequence commands, drive the row and load the result register
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      kept_in       = kept_ff;
      found_in      = found_ff;
      ahead_in      = ahead_ff;
      behind_in     = behind_ff;
      xkey_in       = xkey_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_ahead_in  = rsp_ahead_ff;
      rsp_behind_in = rsp_behind_ff;
      rsp_occ_in    = rsp_occ_ff;
      ctl           = '0;
      wr_pos        = '0;
      wr_data       = req_key;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_key_in    = '0;
               rsp_ahead_in  = '0;
               rsp_behind_in = '0;
               rsp_occ_in    = COUNT_W'(fill_ff);
               unique case (req_opcode)
                  OP_PUSH: begin
                     if (fill_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctl.wr_en  = 1'b1;
                        wr_pos     = IDX_W'(fill_ff);
                        fill_in    = fill_ff + CNT_W'(1);
                        rsp_occ_in = COUNT_W'(fill_in);
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        ctl.shift  = 1'b1;
                        fill_in    = fill_ff - CNT_W'(1);
                        rsp_key_in = head;
                        rsp_occ_in = COUNT_W'(fill_in);
                     end
                  end
                  OP_EXTRACT: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_NOTFOUND;
                     end else begin
                        // hold the result until the rotation is done
                        rsp_valid_in = 1'b0;
                        state_in     = ST_EXTRACT;
                        left_in      = fill_ff;
                        kept_in      = '0;
                        found_in     = 1'b0;
                        ahead_in     = '0;
                        behind_in    = '0;
                        xkey_in      = req_key;
                     end
                  end
                  default: begin
                     // unused opcode: no operation
                  end
               endcase
            end
         end
         ST_EXTRACT: begin
            // advance the row; a kept head rejoins behind the kept keys
            ctl.shift = 1'b1;
            ctl.wr_en = !match;
            wr_pos    = tail_pos[IDX_W-1:0];
            wr_data   = head;
            left_in   = left_ff - CNT_W'(1);
            kept_in   = kept_ff + CNT_W'(!match);
            if (match) begin
               found_in = 1'b1;
            end else if (found_ff) begin
               behind_in = behind_ff + COUNT_W'(1);
            end else begin
               ahead_in = ahead_ff + COUNT_W'(1);
            end
            if (left_ff == CNT_W'(1)) begin
               state_in      = ST_IDLE;
               fill_in       = kept_in;
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_in ? STAT_OK : STAT_NOTFOUND;
               rsp_key_in    = '0;
               rsp_ahead_in  = ahead_in;
               rsp_behind_in = behind_in;
               rsp_occ_in    = COUNT_W'(kept_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      kept_ff       <= kept_in;
      found_ff      <= found_in;
      ahead_ff      <= ahead_in;
      behind_ff     <= behind_in;
      xkey_ff       <= xkey_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_ahead_ff  <= rsp_ahead_in;
      rsp_behind_ff <= rsp_behind_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_ahead_count  = rsp_ahead_ff;
   assign rsp_behind_count = rsp_behind_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // fill count never passes the row length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds depth");

   // no request is taken while a rotation runs
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXTRACT) |-> req_stall)
      else $error("request taken during extract");

   // rotation keeps the unexamined and kept keys inside the queue
   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXTRACT) |->
         ((left_ff != '0) && ((left_ff + kept_ff) <= fill_ff)))
      else $error("extract rotation out of range");

   // the result register is loaded only when the output side is free
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

`default_nettype wire
